@@ rtl/core/cyclic_animation_timer_top_macros.svh @@
// Assertion macros for the cyclic animation timer.
// Included by the top level; no other dependencies.
`ifndef CYCLIC_ANIMATION_TIMER_TOP_MACROS_SVH
`define CYCLIC_ANIMATION_TIMER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/core/catm_pkg.sv @@
// Shared types, codes and widths of the cyclic animation timer.
// No dependencies; imported by every other file but the macros header.
package catm_pkg;

   localparam int CATM_MAX_EVENTS_DEF = 8;
   localparam int CATM_EPSILON_DEF    = 1;

   localparam int TIME_W     = 24;
   localparam int COUNT_W    = 16;
   localparam int SPEED_W    = 16;
   localparam int VALUE_W    = 16;
   localparam int PROG_W     = 17;
   localparam int ACC_W      = 26;
   localparam int A_W        = ACC_W - 1;
   localparam int INC_W      = 32;
   localparam int NOW_W      = 35;
   localparam int ACTION_W   = 2;
   localparam int KIND_W     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam int DIV_W      = 34;
   localparam int DIV_STEP_W = 6;
   localparam int PROD_W     = 35;

   localparam logic [PROG_W-1:0] PROG_ONE = 17'h10000;

   typedef enum logic [ACTION_W-1:0] {
      ACT_TICK   = 2'd0,
      ACT_PLAY   = 2'd1,
      ACT_RESUME = 2'd2,
      ACT_STOP   = 2'd3
   } action_type;

   typedef enum logic [KIND_W-1:0] {
      EV_NONE      = 2'd0,
      EV_START     = 2'd1,
      EV_CYCLE_END = 2'd2,
      EV_ANIM_END  = 2'd3
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CYCLE_TIME  = 3'd0,
      CSR_CYCLE_COUNT = 3'd1,
      CSR_SPEED       = 3'd2,
      CSR_ALTERNATE   = 3'd3,
      CSR_REVERSED    = 3'd4,
      CSR_STOP_AT_END = 3'd5,
      CSR_VALUE_START = 3'd6,
      CSR_VALUE_END   = 3'd7
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_EVAL,
      ST_TDIV,
      ST_TUPD,
      ST_AMOD,
      ST_AWAIT,
      ST_PSET,
      ST_PWAIT,
      ST_VMUL,
      ST_VADD,
      ST_EMIT
   } seq_state_type;

   typedef struct packed {
      logic [TIME_W-1:0]         cycle_time;
      logic [COUNT_W-1:0]        cycle_count;
      logic [SPEED_W-1:0]        speed;
      logic                      alternate;
      logic                      reversed;
      logic                      stop_at_end;
      logic signed [VALUE_W-1:0] value_start;
      logic signed [VALUE_W-1:0] value_end;
   } cfg_type;

   typedef struct packed {
      logic                  start;
      logic [DIV_STEP_W-1:0] steps;
      logic [TIME_W-1:0]     init_rem;
      logic [DIV_W-1:0]      dividend;
      logic [TIME_W-1:0]     divisor;
   } div_ctrl_type;

   typedef struct packed {
      logic              busy;
      logic [DIV_W-1:0]  quotient;
      logic [TIME_W-1:0] remainder;
   } div_stat_type;

endpackage

@@ rtl/core/catm_req_if.sv @@
// Request channel of the cyclic animation timer: valid, ready, action, amount.
// Depends on catm_pkg.
interface catm_req_if import catm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [TIME_W-1:0]   amount;

   modport source (output valid, output action, output amount, input ready);
   modport sink   (input valid, input action, input amount, output ready);
endinterface

@@ rtl/core/catm_rsp_if.sv @@
// Result channel of the cyclic animation timer: valid, ready and result fields.
// Depends on catm_pkg.
interface catm_rsp_if import catm_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [KIND_W-1:0]         event_kind;
   logic [COUNT_W-1:0]        event_index;
   logic [PROG_W-1:0]         progress;
   logic signed [VALUE_W-1:0] value;
   logic                      playing;
   logic                      last;

   modport source (output valid, output event_kind, output event_index, output progress,
                   output value, output playing, output last, input ready);
   modport sink   (input valid, input event_kind, input event_index, input progress,
                   input value, input playing, input last, output ready);
endinterface

@@ rtl/core/catm_div.sv @@
// Shared restoring divider, one quotient bit per cycle, divisor up to 24 bits.
// Depends on catm_pkg.
module catm_div import catm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  div_ctrl_type ctrl,
   output div_stat_type stat
);

   logic                  busy_ff, busy_in;
   logic [DIV_STEP_W-1:0] cnt_ff, cnt_in;
   logic [TIME_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]      dvd_ff, dvd_in;
   logic [DIV_W-1:0]      quo_ff, quo_in;
   logic [TIME_W-1:0]     dsr_ff, dsr_in;

   logic [TIME_W:0] rem_sh;
   logic [TIME_W:0] rem_sub;
   logic            ge;

   assign rem_sh  = {rem_ff, dvd_ff[DIV_W-1]};
   assign rem_sub = rem_sh - {1'b0, dsr_ff};
   assign ge      = rem_sh >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (ctrl.start) begin
         busy_in = 1'b1;
         cnt_in  = ctrl.steps;
         rem_in  = ctrl.init_rem;
         dvd_in  = ctrl.dividend;
         quo_in  = '0;
         dsr_in  = ctrl.divisor;
      end else if (busy_ff) begin
         rem_in  = ge ? rem_sub[TIME_W-1:0] : rem_sh[TIME_W-1:0];
         dvd_in  = {dvd_ff[DIV_W-2:0], 1'b0};
         quo_in  = {quo_ff[DIV_W-2:0], ge};
         cnt_in  = cnt_ff - DIV_STEP_W'(1);
         busy_in = cnt_ff != DIV_STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign stat.busy      = busy_ff;
   assign stat.quotient  = quo_ff;
   assign stat.remainder = rem_ff;

endmodule

@@ rtl/core/catm_seq.sv @@
// Sequencer of the cyclic animation timer: timer state, event bookkeeping,
// progress and value. Drives catm_div; depends on catm_pkg and the channel interfaces.
module catm_seq import catm_pkg::*; #(
   parameter int MAX_EVENTS    = CATM_MAX_EVENTS_DEF,
   parameter int EPSILON_TICKS = CATM_EPSILON_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   catm_req_if.sink     req_bus,
   catm_rsp_if.source   rsp_bus,
   output div_ctrl_type div_ctrl,
   input  div_stat_type div_stat
);

   localparam int EV_CNT_W = $clog2(MAX_EVENTS + 1);
   localparam int N_W      = DIV_W + 1;
   localparam logic [EV_CNT_W-1:0]     EV_MAX = EV_CNT_W'(MAX_EVENTS);
   localparam logic signed [ACC_W-1:0] EPS    = ACC_W'(EPSILON_TICKS);
   localparam logic signed [PROD_W-1:0] ROUND = 35'sd32768;

   seq_state_type state_ff, state_in;

   logic [ACTION_W-1:0]       action_ff, action_in;
   logic [TIME_W-1:0]         amount_ff, amount_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic [COUNT_W-1:0]        cidx_ff, cidx_in;
   logic                      paused_ff, paused_in;
   logic                      stopped_ff, stopped_in;
   logic [INC_W-1:0]          inc_ff, inc_in;
   logic                      has_start_ff, has_start_in;
   logic                      has_end_ff, has_end_in;
   logic [EV_CNT_W-1:0]       n_ce_ff, n_ce_in;
   logic [COUNT_W-1:0]        base_idx_ff, base_idx_in;
   logic [COUNT_W-1:0]        end_idx_ff, end_idx_in;
   logic [EV_CNT_W-1:0]       total_ff, total_in;
   logic [EV_CNT_W-1:0]       k_ff, k_in;
   logic [A_W-1:0]            a_ff, a_in;
   logic [PROG_W-1:0]         p_ff, p_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic [VALUE_W-1:0]        value_ff, value_in;

   logic [TIME_W-1:0]         c_len;
   logic signed [ACC_W-1:0]   thr;
   logic signed [NOW_W-1:0]   now;
   logic signed [NOW_W-1:0]   thr_w;
   logic signed [NOW_W-1:0]   diff;
   logic                      crossing;
   logic                      start_ev;
   logic [SPEED_W+TIME_W-1:0] mul_full;

   logic [N_W-1:0]            n_val;
   logic [COUNT_W-1:0]        rem_cnt;
   logic                      ended;
   logic [N_W-1:0]            iters;
   logic [EV_CNT_W-1:0]       room;
   logic [EV_CNT_W-1:0]       n_ce;
   logic                      room_end;
   logic signed [ACC_W-1:0]   acc_wrap;

   logic [A_W-1:0]            a_pos;
   logic                      a_big;
   logic [ACC_W-1:0]          a2;
   logic [ACC_W-1:0]          c2;
   logic [ACC_W-1:0]          x_full;
   logic [TIME_W-1:0]         x;
   logic [PROG_W-1:0]         q17;
   logic [PROG_W-1:0]         p_clamp;
   logic [PROG_W-1:0]         p_out;
   logic signed [VALUE_W:0]   vdiff;
   logic signed [PROD_W-1:0]  mult;

   logic                      req_fire;
   logic                      rsp_fire;
   logic                      rsp_last;
   logic [EV_CNT_W-1:0]       j;
   kind_type                  kind;
   logic [COUNT_W-1:0]        index;

   // tick arithmetic
   assign c_len    = (cfg.cycle_time == '0) ? TIME_W'(1) : cfg.cycle_time;
   assign thr      = $signed({2'b00, c_len}) - EPS;
   assign mul_full = (SPEED_W+TIME_W)'(cfg.speed) * (SPEED_W+TIME_W)'(amount_ff);
   assign now      = NOW_W'(acc_ff) + $signed({{(NOW_W-INC_W){1'b0}}, inc_ff});
   assign thr_w    = NOW_W'(thr);
   assign diff     = now - thr_w;
   assign crossing = now >= thr_w;
   assign start_ev = acc_ff[ACC_W-1] && !now[NOW_W-1];

   // cycle boundary bookkeeping
   assign n_val    = {1'b0, div_stat.quotient} + N_W'(1);
   assign rem_cnt  = (cfg.cycle_count > cidx_ff) ? cfg.cycle_count - cidx_ff : COUNT_W'(1);
   assign ended    = (cfg.cycle_count != '0) && (n_val >= N_W'(rem_cnt));
   assign iters    = ended ? N_W'(rem_cnt) : n_val;
   assign room     = EV_MAX - EV_CNT_W'(has_start_ff);
   assign n_ce     = (iters >= N_W'(room)) ? room : iters[EV_CNT_W-1:0];
   assign room_end = (EV_CNT_W'(has_start_ff) + n_ce) < EV_MAX;
   assign acc_wrap = thr + $signed({2'b00, div_stat.remainder}) - $signed({2'b00, c_len});

   // progress
   assign a_pos   = acc_ff[ACC_W-1] ? '0 : acc_ff[A_W-1:0];
   assign a_big   = a_pos > A_W'(c_len);
   assign a2      = {a_ff, 1'b0};
   assign c2      = {1'b0, c_len, 1'b0};
   assign x_full  = !cfg.alternate ? {1'b0, a_ff} :
                    (a2 < {2'b00, c_len}) ? a2 : c2 - a2;
   assign x       = x_full[TIME_W-1:0];
   assign q17     = div_stat.quotient[PROG_W-1:0];
   assign p_clamp = (q17 > PROG_ONE) ? PROG_ONE : q17;
   assign p_out   = cfg.reversed ? PROG_ONE - p_clamp : p_clamp;
   assign vdiff   = $signed({cfg.value_end[VALUE_W-1], cfg.value_end})
                  - $signed({cfg.value_start[VALUE_W-1], cfg.value_start});
   assign mult    = vdiff * $signed({1'b0, p_ff});

   assign req_fire = req_bus.valid && req_bus.ready;
   assign rsp_fire = rsp_bus.valid && rsp_bus.ready;
   assign rsp_last = (total_ff == '0) || (k_ff == total_ff - EV_CNT_W'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_fire) state_in = ST_MUL;
         ST_MUL: begin
            if (action_type'(action_ff) == ACT_TICK && !paused_ff && !stopped_ff)
               state_in = ST_EVAL;
            else
               state_in = ST_AMOD;
         end
         ST_EVAL:  state_in = crossing ? ST_TDIV : ST_AMOD;
         ST_TDIV:  if (!div_stat.busy) state_in = ST_TUPD;
         ST_TUPD:  state_in = ST_AMOD;
         ST_AMOD:  state_in = a_big ? ST_AWAIT : ST_PSET;
         ST_AWAIT: if (!div_stat.busy) state_in = ST_PSET;
         ST_PSET:  state_in = ST_PWAIT;
         ST_PWAIT: if (!div_stat.busy) state_in = ST_VMUL;
         ST_VMUL:  state_in = ST_VADD;
         ST_VADD:  state_in = ST_EMIT;
         ST_EMIT:  if (rsp_fire && rsp_last) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs: divider launch
   always_comb begin
      div_ctrl.start    = 1'b0;
      div_ctrl.steps    = '0;
      div_ctrl.init_rem = '0;
      div_ctrl.dividend = '0;
      div_ctrl.divisor  = c_len;
      case (state_ff)
         ST_EVAL: begin
            div_ctrl.start    = crossing;
            div_ctrl.steps    = DIV_STEP_W'(DIV_W);
            div_ctrl.dividend = diff[DIV_W-1:0];
         end
         ST_AMOD: begin
            div_ctrl.start    = a_big;
            div_ctrl.steps    = DIV_STEP_W'(A_W);
            div_ctrl.dividend = {a_pos, {(DIV_W-A_W){1'b0}}};
         end
         ST_PSET: begin
            div_ctrl.start    = 1'b1;
            div_ctrl.steps    = DIV_STEP_W'(PROG_W);
            div_ctrl.init_rem = {1'b0, x[TIME_W-1:1]};
            div_ctrl.dividend = {x[0], {(DIV_W-1){1'b0}}};
         end
         default: begin
            div_ctrl.start = 1'b0;
         end
      endcase
   end

   // result fields
   always_comb begin
      j     = k_ff - EV_CNT_W'(has_start_ff);
      kind  = EV_NONE;
      index = '0;
      if (total_ff == '0) begin
         kind  = EV_NONE;
      end else if (has_start_ff && k_ff == '0) begin
         kind  = EV_START;
      end else if (j < n_ce_ff) begin
         kind  = EV_CYCLE_END;
         index = base_idx_ff + COUNT_W'(j);
      end else begin
         kind  = EV_ANIM_END;
         index = end_idx_ff;
      end
   end

   assign req_bus.ready       = state_ff == ST_IDLE;
   assign rsp_bus.valid       = state_ff == ST_EMIT;
   assign rsp_bus.event_kind  = kind;
   assign rsp_bus.event_index = index;
   assign rsp_bus.progress    = p_ff;
   assign rsp_bus.value       = value_ff;
   assign rsp_bus.playing     = !paused_ff && !stopped_ff;
   assign rsp_bus.last        = rsp_last;

   // datapath
   always_comb begin
      action_in    = action_ff;
      amount_in    = amount_ff;
      acc_in       = acc_ff;
      cidx_in      = cidx_ff;
      paused_in    = paused_ff;
      stopped_in   = stopped_ff;
      inc_in       = inc_ff;
      has_start_in = has_start_ff;
      has_end_in   = has_end_ff;
      n_ce_in      = n_ce_ff;
      base_idx_in  = base_idx_ff;
      end_idx_in   = end_idx_ff;
      total_in     = total_ff;
      k_in         = k_ff;
      a_in         = a_ff;
      p_in         = p_ff;
      prod_in      = prod_ff;
      value_in     = value_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               action_in = req_bus.action;
               amount_in = req_bus.amount;
            end
         end
         ST_MUL: begin
            inc_in       = mul_full[SPEED_W+TIME_W-1:8];
            has_start_in = 1'b0;
            has_end_in   = 1'b0;
            n_ce_in      = '0;
            case (action_type'(action_ff))
               ACT_PLAY: begin
                  acc_in     = -$signed({2'b00, amount_ff});
                  cidx_in    = '0;
                  paused_in  = 1'b0;
                  stopped_in = 1'b0;
               end
               ACT_RESUME: begin
                  paused_in  = 1'b0;
                  stopped_in = 1'b0;
               end
               ACT_STOP: stopped_in = 1'b1;
               default:  acc_in = acc_ff;
            endcase
         end
         ST_EVAL: begin
            has_start_in = start_ev;
            if (!crossing) acc_in = now[ACC_W-1:0];
         end
         ST_TUPD: begin
            n_ce_in     = n_ce;
            base_idx_in = cidx_ff;
            end_idx_in  = cidx_ff + rem_cnt;
            has_end_in  = ended && room_end;
            if (ended) begin
               acc_in    = $signed({2'b00, c_len});
               cidx_in   = cidx_ff + rem_cnt;
               paused_in = 1'b1;
               if (cfg.stop_at_end) stopped_in = 1'b1;
            end else begin
               acc_in  = acc_wrap;
               cidx_in = cidx_ff + iters[COUNT_W-1:0];
            end
         end
         ST_AMOD:  if (!a_big) a_in = a_pos;
         ST_AWAIT: if (!div_stat.busy) a_in = {1'b0, div_stat.remainder};
         ST_PWAIT: if (!div_stat.busy) p_in = p_out;
         ST_VMUL:  prod_in = mult + ROUND;
         ST_VADD: begin
            value_in = cfg.value_start + prod_ff[31:16];
            k_in     = '0;
            total_in = EV_CNT_W'(has_start_ff) + n_ce_ff + EV_CNT_W'(has_end_ff);
         end
         ST_EMIT:  if (rsp_fire) k_in = k_ff + EV_CNT_W'(1);
         default:  k_in = k_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         acc_ff     <= '0;
         cidx_ff    <= '0;
         paused_ff  <= 1'b0;
         stopped_ff <= 1'b0;
         k_ff       <= '0;
         total_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         acc_ff     <= acc_in;
         cidx_ff    <= cidx_in;
         paused_ff  <= paused_in;
         stopped_ff <= stopped_in;
         k_ff       <= k_in;
         total_ff   <= total_in;
      end
      action_ff    <= action_in;
      amount_ff    <= amount_in;
      inc_ff       <= inc_in;
      has_start_ff <= has_start_in;
      has_end_ff   <= has_end_in;
      n_ce_ff      <= n_ce_in;
      base_idx_ff  <= base_idx_in;
      end_idx_ff   <= end_idx_in;
      a_ff         <= a_in;
      p_ff         <= p_in;
      prod_ff      <= prod_in;
      value_ff     <= value_in;
   end

endmodule

@@ rtl/core/cyclic_animation_timer_top.sv @@
// Top level of the cyclic animation timer: configuration registers, sequencer, divider.
// Depends on catm_pkg, catm_req_if, catm_rsp_if, catm_div, catm_seq and the macros header.
//
// One request at a time. A tick while playing divides for the cycle count when it reaches
// a cycle boundary; play, resume, stop and a tick while paused or stopped skip that step.
// Any request then divides the accumulator when it lies beyond the cycle length, and
// divides for the progress ratio. Then one cycle per result while the result channel is
// ready (1 to MAX_EVENTS results); the next request is taken the cycle after the
// last result is delivered. The shared restoring divider, one quotient bit per cycle,
// runs 34 steps for a tick's cycle count, 25 for the accumulator wrap, 17 for the ratio.
// Configuration writes take effect at once and must be made while no request is open.
`include "cyclic_animation_timer_top_macros.svh"
module cyclic_animation_timer_top import catm_pkg::*; #(
   parameter int MAX_EVENTS    = CATM_MAX_EVENTS_DEF,
   parameter int EPSILON_TICKS = CATM_EPSILON_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   catm_req_if.sink              req_bus,
   catm_rsp_if.source            rsp_bus,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type      cfg_ff, cfg_in;
   div_ctrl_type div_ctrl;
   div_stat_type div_stat;
   logic         rsp_fire;
   logic         rsp_none;
   logic         rsp_start;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_CYCLE_TIME:  cfg_in.cycle_time  = csr_wdata[TIME_W-1:0];
            CSR_CYCLE_COUNT: cfg_in.cycle_count = csr_wdata[COUNT_W-1:0];
            CSR_SPEED:       cfg_in.speed       = csr_wdata[SPEED_W-1:0];
            CSR_ALTERNATE:   cfg_in.alternate   = csr_wdata[0];
            CSR_REVERSED:    cfg_in.reversed    = csr_wdata[0];
            CSR_STOP_AT_END: cfg_in.stop_at_end = csr_wdata[0];
            CSR_VALUE_START: cfg_in.value_start = csr_wdata[VALUE_W-1:0];
            CSR_VALUE_END:   cfg_in.value_end   = csr_wdata[VALUE_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cycle_time  <= TIME_W'(1000);
         cfg_ff.cycle_count <= '0;
         cfg_ff.speed       <= SPEED_W'(256);
         cfg_ff.alternate   <= 1'b0;
         cfg_ff.reversed    <= 1'b0;
         cfg_ff.stop_at_end <= 1'b0;
         cfg_ff.value_start <= '0;
         cfg_ff.value_end   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   catm_div u_div (
      .clock (clock),
      .reset (reset),
      .ctrl  (div_ctrl),
      .stat  (div_stat)
   );

   catm_seq #(
      .MAX_EVENTS    (MAX_EVENTS),
      .EPSILON_TICKS (EPSILON_TICKS)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_bus  (req_bus),
      .rsp_bus  (rsp_bus),
      .div_ctrl (div_ctrl),
      .div_stat (div_stat)
   );

   assign rsp_fire  = rsp_bus.valid && rsp_bus.ready;
   assign rsp_none  = rsp_bus.valid && rsp_bus.event_kind == EV_NONE;
   assign rsp_start = rsp_bus.valid && rsp_bus.event_kind == EV_START;

   `ASSERT_IMPLY(a_one_side, clock, reset, rsp_bus.valid, !req_bus.ready)
   `ASSERT_IMPLY(a_none_last, clock, reset, rsp_none, rsp_bus.last)
   `ASSERT_IMPLY(a_start_idx, clock, reset, rsp_start, rsp_bus.event_index == '0)
   `ASSERT_IMPLY(a_prog_max, clock, reset, rsp_bus.valid, rsp_bus.progress <= PROG_ONE)
   `ASSERT_NEXT(a_more_follow, clock, reset, rsp_fire && !rsp_bus.last, rsp_bus.valid)

endmodule
